// File: rtl/core/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// TGA run-length decoder package
// Shared types and register indexes for the TGA pixel-data decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_HAS_ALPHA    = 2'd2;
   localparam logic [1:0] CSR_RLE_MODE     = 2'd3;

   // Packet header layout
   localparam int unsigned RUN_FLAG_BIT = 7;

   // Byte slot that completes a pixel, with and without alpha
   localparam logic [1:0] LAST_SLOT_RGB  = 2'd2;
   localparam logic [1:0] LAST_SLOT_RGBA = 2'd3;

   typedef struct packed {
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        has_alpha;
      logic        rle_mode;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  packet_left;
      logic        packet_is_run;
      logic [1:0]  byte_slot;
      logic [7:0]  pix_blue;
      logic [7:0]  pix_green;
      logic [7:0]  pix_red;
      logic [31:0] pixels_left;
      logic        finished;
   } dec_state_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic       last_pixel;
      logic       overrun;
   } pixel_type;

endpackage

// File: rtl/core/tgarle_decode.sv
// ----------------------------------------------------------------------------
// TGA run-length decoder step
// Next-state and pixel logic for one accepted byte of the pixel stream.
// ----------------------------------------------------------------------------
module tgarle_decode (
   input  tgarle_pkg::cfg_type       cfg,
   input  tgarle_pkg::dec_state_type cur,
   input  logic [7:0]                data_byte,
   output tgarle_pkg::dec_state_type nxt,
   output logic                      emit,
   output tgarle_pkg::pixel_type     pix
);
   import tgarle_pkg::*;

   logic [1:0]  last_slot;
   logic [7:0]  count;
   logic        over;
   logic [31:0] left_after;

   assign last_slot = cfg.has_alpha ? LAST_SLOT_RGBA : LAST_SLOT_RGB;

   always_comb begin
      nxt        = cur;
      emit       = 1'b0;
      pix        = '0;
      count      = 8'd1;
      over       = 1'b0;
      left_after = cur.pixels_left;

      if (cur.finished) begin
         // image complete: byte dropped
      end else if (cfg.rle_mode && (cur.packet_left == 8'd0)) begin
         // packet header
         nxt.packet_is_run = data_byte[RUN_FLAG_BIT];
         nxt.packet_left   = {1'b0, data_byte[6:0]} + 8'd1;
         nxt.byte_slot     = 2'd0;
      end else if (cur.byte_slot < last_slot) begin
         // collect a colour byte
         case (cur.byte_slot)
            2'd0:    nxt.pix_blue  = data_byte;
            2'd1:    nxt.pix_green = data_byte;
            2'd2:    nxt.pix_red   = data_byte;
            default: ;
         endcase
         nxt.byte_slot = cur.byte_slot + 2'd1;
      end else begin
         // final byte of a pixel
         emit          = 1'b1;
         nxt.byte_slot = 2'd0;
         pix.blue      = cur.pix_blue;
         pix.green     = cur.pix_green;
         pix.red       = cfg.has_alpha ? cur.pix_red : data_byte;
         pix.alpha     = cfg.has_alpha ? data_byte : 8'd0;

         if (cfg.rle_mode) begin
            if (cur.packet_is_run) begin
               count           = cur.packet_left;
               nxt.packet_left = 8'd0;
            end else begin
               nxt.packet_left = cur.packet_left - 8'd1;
            end
         end

         // clip a run at the image end
         if ({24'd0, count} > cur.pixels_left) begin
            count = cur.pixels_left[7:0];
            over  = 1'b1;
         end
         left_after       = cur.pixels_left - {24'd0, count};
         nxt.pixels_left  = left_after;
         nxt.finished     = (left_after == 32'd0);
         pix.repeat_count = count;
         pix.last_pixel   = (left_after == 32'd0);
         pix.overrun      = over;
      end
   end

endmodule

// File: rtl/core/tga_rle_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// TGA pixel-data decoder
// Decodes uncompressed (type 2) or run-length (type 10) TGA pixel data.
// ----------------------------------------------------------------------------
// One byte is taken per clock, every clock, while the result register is
// free or being emptied in the same cycle. The whole decode of a byte sits
// between the state registers and the result register, so a pixel appears
// on the rsp port in the cycle after its last byte. Header bytes and colour
// bytes that do not complete a pixel give no beat. A run packet comes out
// as one pixel with repeat_count up to 128. After width times height pixels
// all bytes are dropped until any csr write, which also restarts decoding.
// The csr port is always ready; writes belong in idle periods only.
module tga_rle_pixel_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   // byte stream
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   // decoded pixels
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_count,
   output logic        rsp_last_pixel,
   output logic        rsp_overrun,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tgarle_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   dec_state_type state_ff, state_nxt;
   logic          emit;
   pixel_type     pix;
   pixel_type     rsp_ff;
   logic          rsp_valid_ff;
   logic          req_fire;
   logic          csr_fire;
   logic [31:0]   area;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;

   // register file write
   always_comb begin
      cfg_in = cfg_ff;
      case (csr_index)
         CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata;
         CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata;
         CSR_HAS_ALPHA:    cfg_in.has_alpha    = csr_wdata[0];
         CSR_RLE_MODE:     cfg_in.rle_mode     = csr_wdata[0];
         default:          cfg_in = cfg_ff;
      endcase
   end

   // pixel count of the new image size
   assign area = {16'd0, cfg_in.image_width} * {16'd0, cfg_in.image_height};

   tgarle_decode u_decode (
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .data_byte (req_data_byte),
      .nxt       (state_nxt),
      .emit      (emit),
      .pix       (pix)
   );

   // configuration and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '{image_width: 16'd1, image_height: 16'd1,
                       has_alpha: 1'b0, rle_mode: 1'b0};
         state_ff <= '{packet_left: 8'd0, packet_is_run: 1'b0, byte_slot: 2'd0,
                       pix_blue: 8'd0, pix_green: 8'd0, pix_red: 8'd0,
                       pixels_left: 32'd1, finished: 1'b0};
      end else if (csr_fire) begin
         cfg_ff   <= cfg_in;
         state_ff <= '{packet_left: 8'd0, packet_is_run: 1'b0, byte_slot: 2'd0,
                       pix_blue: 8'd0, pix_green: 8'd0, pix_red: 8'd0,
                       pixels_left: area, finished: (area == 32'd0)};
      end else if (req_fire) begin
         state_ff <= state_nxt;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_ff <= pix;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = rsp_ff.red;
   assign rsp_green        = rsp_ff.green;
   assign rsp_blue         = rsp_ff.blue;
   assign rsp_alpha        = rsp_ff.alpha;
   assign rsp_repeat_count = rsp_ff.repeat_count;
   assign rsp_last_pixel   = rsp_ff.last_pixel;
   assign rsp_overrun      = rsp_ff.overrun;

endmodule

// File: rtl/core/tgarle_checker.sv
// ----------------------------------------------------------------------------
// TGA run-length decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module tgarle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_blue,
   input logic [7:0]  rsp_alpha,
   input logic [7:0]  rsp_repeat_count,
   input logic        rsp_last_pixel,
   input logic        rsp_overrun,
   input logic        csr_valid,
   input logic        csr_ready
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue) && $stable(rsp_alpha) && $stable(rsp_repeat_count))
      else $error("rsp beat changed while stalled");

   // a repeat count is always 1..128
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count != 8'd0 && rsp_repeat_count <= 8'd128)
      else $error("repeat count out of range");

   // clipping only happens on the image's final beat
   a_overrun_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overrun |-> rsp_last_pixel)
      else $error("overrun on a beat that does not end the image");

   // no beat directly follows the final pixel, unless a csr write restarts decoding
   a_quiet_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_pixel && !(csr_valid && csr_ready) |=> !rsp_valid)
      else $error("beat after image end");

   // an empty result register never blocks the byte stream
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with empty result register");

endmodule

bind tga_rle_pixel_decoder_unit tgarle_checker u_tgarle_checker (.*);

// File: dv/tga_pixel_checker.sv
// ----------------------------------------------------------------------------
// TGA pixel decoder checker
// Watches the byte, pixel and csr channels of the decoder, keeps its own
// decode state, predicts each pixel beat and compares it field by field.
// ----------------------------------------------------------------------------
module tga_pixel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic [7:0]  rsp_alpha,
   input  logic [7:0]  rsp_repeat_count,
   input  logic        rsp_last_pixel,
   input  logic        rsp_overrun,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int unsigned mismatches,
   output int unsigned pixels_due
);
   import tgarle_pkg::*;

   cfg_type       cfg;
   dec_state_type dec;
   pixel_type     expected_pixels[$];

   // one line per mismatch
   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] pixel mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string field, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
   endtask

   // drop any partial pixel or packet and reload the pixel budget
   task automatic restart_decode();
      dec = '0;
      dec.pixels_left = {16'd0, cfg.image_width} * {16'd0, cfg.image_height};
      dec.finished    = (dec.pixels_left == 32'd0);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
      case (idx)
         CSR_IMAGE_WIDTH:  cfg.image_width  = val;
         CSR_IMAGE_HEIGHT: cfg.image_height = val;
         CSR_HAS_ALPHA:    cfg.has_alpha    = val[0];
         CSR_RLE_MODE:     cfg.rle_mode     = val[0];
         default: ;
      endcase
      restart_decode();
   endtask

   // decode one stream byte; a completed pixel queues an expected beat
   task automatic decode_byte(input logic [7:0] b);
      pixel_type   px;
      logic [1:0]  last_slot;
      logic [31:0] count;
      last_slot = cfg.has_alpha ? LAST_SLOT_RGBA : LAST_SLOT_RGB;
      if (dec.finished)
         return;
      // packet header
      if (cfg.rle_mode && dec.packet_left == 8'd0) begin
         dec.packet_is_run = b[RUN_FLAG_BIT];
         dec.packet_left   = {1'b0, b[6:0]} + 8'd1;
         dec.byte_slot     = 2'd0;
         return;
      end
      // colour bytes stored in arrival order: blue, green, red
      if (dec.byte_slot < last_slot) begin
         case (dec.byte_slot)
            2'd0:    dec.pix_blue  = b;
            2'd1:    dec.pix_green = b;
            default: dec.pix_red   = b;
         endcase
         dec.byte_slot = dec.byte_slot + 2'd1;
         return;
      end
      px.blue       = dec.pix_blue;
      px.green      = dec.pix_green;
      px.red        = cfg.has_alpha ? dec.pix_red : b;
      px.alpha      = cfg.has_alpha ? b : 8'd0;
      dec.byte_slot = 2'd0;
      count         = 32'd1;
      if (cfg.rle_mode) begin
         if (dec.packet_is_run) begin
            count           = {24'd0, dec.packet_left};
            dec.packet_left = 8'd0;
         end else begin
            dec.packet_left = dec.packet_left - 8'd1;
         end
      end
      // clip a run that would go past the image end
      px.overrun = (count > dec.pixels_left);
      if (px.overrun)
         count = dec.pixels_left;
      dec.pixels_left = dec.pixels_left - count;
      dec.finished    = (dec.pixels_left == 32'd0);
      px.repeat_count = count[7:0];
      px.last_pixel   = dec.finished;
      expected_pixels.push_back(px);
   endtask

   task automatic check_pixel();
      pixel_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("unexpected beat rgba %0h %0h %0h %0h count %0d",
                                   rsp_red, rsp_green, rsp_blue, rsp_alpha,
                                   rsp_repeat_count));
         return;
      end
      want = expected_pixels.pop_front();
      check_field("red", rsp_red, want.red);
      check_field("green", rsp_green, want.green);
      check_field("blue", rsp_blue, want.blue);
      check_field("alpha", rsp_alpha, want.alpha);
      check_field("repeat_count", rsp_repeat_count, want.repeat_count);
      check_field("last_pixel", {7'd0, rsp_last_pixel}, {7'd0, want.last_pixel});
      check_field("overrun", {7'd0, rsp_overrun}, {7'd0, want.overrun});
   endtask

   // older beats are compared before the byte taken at the same edge is decoded
   always @(posedge clock) begin
      if (reset) begin
         cfg.image_width  = 16'd1;
         cfg.image_height = 16'd1;
         cfg.has_alpha    = 1'b0;
         cfg.rle_mode     = 1'b0;
         restart_decode();
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_pixel();
         if (csr_valid && csr_ready)
            write_register(csr_index, csr_wdata);
         if (req_valid && req_ready)
            decode_byte(req_data_byte);
      end
      pixels_due = expected_pixels.size();
   end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// TGA pixel decoder testbench
// Feeds directed and random TGA pixel streams (raw and run-length, with and
// without alpha) under random idling on both sides; the checker compares.
// ----------------------------------------------------------------------------
module tb_top;
   import tgarle_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned LIVE_TARGET = 1600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_repeat_count;
   logic        rsp_last_pixel;
   logic        rsp_overrun;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [15:0] csr_wdata = 16'd0;

   int unsigned mismatches;
   int unsigned pixels_due;

   // stimulus-side view of the image being sent
   bit          cur_alpha;
   bit          cur_rle;
   longint      img_left = 1;
   bit          no_idle = 1'b0;
   bit          noise_on = 1'b0;
   int unsigned live_bytes = 0;
   int unsigned quiet_cycles = 0;

   always #4 clock = ~clock;

   tga_rle_pixel_decoder_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_last_pixel   (rsp_last_pixel),
      .rsp_overrun      (rsp_overrun),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   tga_pixel_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_last_pixel   (rsp_last_pixel),
      .rsp_overrun      (rsp_overrun),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .pixels_due       (pixels_due)
   );

   // watchdog: too long without any beat on any channel ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // pixel sink: random stall before each beat, none in no-idle stretches
   initial begin
      int unsigned stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   // one stream beat; ready is sampled mid-cycle, where it is settled
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (img_left != 0 || noise_on)
         live_bytes++;
   endtask

   // argb packed as alpha, red, green, blue; sent blue first
   task automatic send_pixel(input logic [31:0] argb);
      send_byte(argb[7:0]);
      send_byte(argb[15:8]);
      send_byte(argb[23:16]);
      if (cur_alpha)
         send_byte(argb[31:24]);
   endtask

   task automatic take_pixels(input longint n);
      img_left = (n > img_left) ? 0 : img_left - n;
   endtask

   task automatic send_packet(input bit is_run, input int unsigned n);
      logic [7:0] hdr;
      hdr = 8'(n - 1);
      hdr[RUN_FLAG_BIT] = is_run;
      send_byte(hdr);
      if (is_run) begin
         send_pixel($urandom);
         take_pixels(n);
      end else begin
         repeat (n) begin
            send_pixel($urandom);
            take_pixels(1);
         end
      end
   endtask

   // stop sending and wait for every outstanding pixel, plus a short tail
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pixels_due != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
   endtask

   // flag registers get random upper bits, which the block must ignore
   task automatic configure(input logic [15:0] w, input logic [15:0] h,
                            input bit a, input bit r);
      logic [15:0] junk;
      drain();
      junk = 16'($urandom);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_HAS_ALPHA, {junk[15:1], a});
      junk = 16'($urandom);
      write_reg(CSR_RLE_MODE, {junk[15:1], r});
      csr_valid <= 1'b0;
      cur_alpha = a;
      cur_rle   = r;
      img_left  = longint'(w);
      img_left  = img_left * h;
   endtask

   // well-formed packets with random content, then an optional ragged tail
   task automatic send_image();
      int unsigned budget;
      int unsigned n;
      bit          is_run;
      budget = $urandom_range(1, 60);
      while (img_left > 0 && budget > 0) begin
         if (cur_rle) begin
            n      = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128)
                                                 : $urandom_range(1, 8);
            is_run = 1'($urandom_range(0, 1));
            if (!is_run && n > img_left + 3)
               n = 32'(img_left) + $urandom_range(0, 3);
            send_packet(is_run, n);
         end else begin
            send_pixel($urandom);
            take_pixels(1);
         end
         budget--;
         if ($urandom_range(0, 49) == 0)
            drain();
      end
      case ($urandom_range(0, 5))
         0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         1: repeat ($urandom_range(1, cur_alpha ? 3 : 2)) send_byte(8'($urandom));
         2: if (cur_rle) send_byte(8'($urandom));
         default: ;
      endcase
   endtask

   initial begin
      logic [15:0] w;
      logic [15:0] h;
      int unsigned pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults after reset: one raw pixel, then a byte past the end
      no_idle   = 1'b1;
      cur_alpha = 1'b0;
      cur_rle   = 1'b0;
      send_pixel(32'h00FF8001);
      take_pixels(1);
      send_byte(8'hA5);

      // largest image, alpha, longest run and raw packets, cut mid-pixel
      configure(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      send_byte(8'hFF);
      send_pixel(32'hFFFFFFFF);
      take_pixels(128);
      send_byte(8'h00);
      send_pixel(32'h00000000);
      take_pixels(1);
      send_byte(8'h7F);
      send_pixel(32'h5AC33CA5);
      take_pixels(1);
      send_byte(8'h12);
      send_byte(8'h34);

      // run clipped at the image end
      configure(16'd3, 16'd1, 1'b0, 1'b1);
      send_packet(1'b1, 5);

      // raw packet reaching past the image end
      configure(16'd1, 16'd2, 1'b0, 1'b1);
      send_packet(1'b0, 3);

      // empty images ignore every byte
      configure(16'd0, 16'd7, 1'b1, 1'b0);
      send_pixel(32'h11223344);
      configure(16'd5, 16'd0, 1'b0, 1'b1);
      send_byte(8'h81);

      // raw mode, two pixels
      no_idle = 1'b0;
      configure(16'd2, 16'd1, 1'b0, 1'b0);
      send_pixel($urandom);
      send_pixel($urandom);
      take_pixels(2);

      // random phases: mostly small images, a few empty or huge ones
      while (live_bytes < LIVE_TARGET) begin
         no_idle = ($urandom_range(0, 3) == 0);
         pick    = $urandom_range(0, 99);
         if (pick < 4) begin
            w = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 6));
            h = (w == 16'd0) ? 16'($urandom_range(0, 6)) : 16'd0;
         end else if (pick < 9) begin
            w = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1, 65535));
            h = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1, 65535));
         end else begin
            w = 16'($urandom_range(1, 6));
            h = 16'($urandom_range(1, 6));
         end
         configure(w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 9) == 0) begin
            noise_on = 1'b1;
            repeat ($urandom_range(1, 30)) send_byte(8'($urandom));
            noise_on = 1'b0;
         end else begin
            send_image();
         end
      end

      drain();
      if (mismatches == 0 && pixels_due == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
